@@ src/esr_pkg.sv @@
// shared types, widths and codes for the ellipse span rasterizer
package esr_pkg;

  // default screen size
  localparam int SCREEN_WIDTH_DEF  = 800;
  localparam int SCREEN_HEIGHT_DEF = 480;

  // field widths
  localparam int COORD_W = 12;   // box fields
  localparam int COL_W   = 13;   // centre and span column
  localparam int ROW_W   = 10;   // clipped row fields
  localparam int COLOR_W = 16;
  localparam int AXIS_W  = 10;   // positive semi-axis
  localparam int A2_W    = 21;   // squared semi-axis
  localparam int STEP_W  = 11;   // signed walk offsets
  localparam int SLOPE_W = 34;   // 2*b^2*x and 2*a^2*y
  localparam int TERM_W  = 36;   // decision increment before scaling
  localparam int DEC_W   = 46;   // decision, bounded near 8*a^2*b^2
  localparam int MUL_W   = 26;   // shared multiplier operands
  localparam int PROD_W  = 2 * MUL_W;
  localparam int SPAN_W  = 14;   // span arithmetic before clipping

  // stream widths
  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_USER_W = 2;

  // command queue between front and back
  localparam int CMD_DEPTH = 2;

  // result flags in out_tuser
  localparam int USER_VISIBLE = 0;
  localparam int USER_DONE    = 1;

  typedef enum logic {
    REQ_BEGIN = 1'b0,
    REQ_NEXT  = 1'b1
  } req_type_t;

  typedef struct packed {
    logic                     is_begin;
    logic                     degenerate;
    logic signed [COL_W-1:0]  centre_col;
    logic signed [COL_W-1:0]  centre_row;
    logic [AXIS_W-1:0]        axis_a;
    logic [AXIS_W-1:0]        axis_b;
    logic [COLOR_W-1:0]       color;
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_AA,
    ST_MUL_BB,
    ST_MUL_AB,
    ST_SETUP,
    ST_R1_STEP,
    ST_R1_TERM,
    ST_R1_ACC,
    ST_TR_TX,
    ST_TR_BTX,
    ST_TR_TY,
    ST_TR_ATY,
    ST_TR_AB,
    ST_TR_FIN,
    ST_R2_STEP,
    ST_R2_TERM,
    ST_R2_ACC,
    ST_EMIT_POS,
    ST_EMIT_NEG,
    ST_EMIT_DONE
  } back_state_t;

endpackage

@@ src/esr_front.sv @@
// front end: accepts input beats and decodes them into commands
module esr_front import esr_pkg::*; (
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic [IN_USER_W-1:0] in_tuser,
  input  logic                 q_full,
  output logic                 q_push,
  output cmd_t                 q_cmd
);

  logic signed [COORD_W-1:0] left, top, wid, hgt;
  logic signed [COORD_W-1:0] wid_adj, hgt_adj;
  logic signed [COORD_W-2:0] half_w, half_h;

  assign left = in_tdata[COORD_W-1:0];
  assign top  = in_tdata[2*COORD_W-1:COORD_W];
  assign wid  = in_tdata[3*COORD_W-1:2*COORD_W];
  assign hgt  = in_tdata[4*COORD_W-1:3*COORD_W];

  // halving truncates toward zero: bias negatives by one before the shift
  assign wid_adj = wid + COORD_W'(wid[COORD_W-1]);
  assign hgt_adj = hgt + COORD_W'(hgt[COORD_W-1]);
  assign half_w  = wid_adj[COORD_W-1:1];
  assign half_h  = hgt_adj[COORD_W-1:1];

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_cmd.is_begin   = (req_type_t'(in_tuser[0]) == REQ_BEGIN);
    q_cmd.degenerate = half_w[COORD_W-2] || (half_w == '0) ||
                       half_h[COORD_W-2] || (half_h == '0);
    q_cmd.centre_col = COL_W'(left) + COL_W'(half_w);
    q_cmd.centre_row = COL_W'(top) + COL_W'(half_h);
    q_cmd.axis_a     = half_w[AXIS_W-1:0];
    q_cmd.axis_b     = half_h[AXIS_W-1:0];
    q_cmd.color      = in_tdata[4*COORD_W+COLOR_W-1:4*COORD_W];
  end

endmodule

@@ src/esr_cmd_queue.sv @@
// short command queue that decouples the front end from the span engine
module esr_cmd_queue import esr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic valid
);

  localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CMD_DEPTH - 1);

  cmd_t             mem_r [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(CMD_DEPTH));
  assign valid   = (count_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign pop_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CMD_DEPTH))
    else $error("command queue holds more entries than its depth");

endmodule

@@ src/esr_back.sv @@
// span engine: midpoint ellipse walk, shared multiplier and result register
module esr_back import esr_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  input  cmd_t                  cmd,
  output logic                  cmd_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser,
  output logic                  out_tlast
);

  localparam logic signed [SPAN_W-1:0] COL_LIM = SPAN_W'(SCREEN_WIDTH);
  localparam logic signed [SPAN_W-1:0] ROW_MAX = SPAN_W'(SCREEN_HEIGHT - 1);
  localparam int PAD_W = OUT_DATA_W - COL_W - 2 * ROW_W - COLOR_W;

  back_state_t               state_r, state_nxt;
  logic signed [COL_W-1:0]   centre_col_r, centre_col_nxt;
  logic signed [COL_W-1:0]   centre_row_r, centre_row_nxt;
  logic [AXIS_W-1:0]         axis_a_r, axis_a_nxt;
  logic [AXIS_W-1:0]         axis_b_r, axis_b_nxt;
  logic [A2_W-1:0]           a2_r, a2_nxt;
  logic [A2_W-1:0]           b2_r, b2_nxt;
  logic signed [STEP_W-1:0]  step_x_r, step_x_nxt;
  logic signed [STEP_W-1:0]  step_y_r, step_y_nxt;
  logic signed [STEP_W-1:0]  x0_r, x0_nxt;
  logic signed [STEP_W-1:0]  y0_r, y0_nxt;
  logic signed [DEC_W-1:0]   dec_r, dec_nxt;
  logic signed [DEC_W-1:0]   acc_r, acc_nxt;
  logic signed [SLOPE_W-1:0] sx_r, sx_nxt;
  logic signed [SLOPE_W-1:0] sy_r, sy_nxt;
  logic signed [TERM_W-1:0]  term_r, term_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic                      ystep_r, ystep_nxt;
  logic                      xstep_r, xstep_nxt;
  logic                      tr_r, tr_nxt;
  logic                      region2_r, region2_nxt;
  logic                      finished_r, finished_nxt;
  logic [COLOR_W-1:0]        color_r, color_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [COL_W-1:0]          out_col_r, out_col_nxt;
  logic [ROW_W-1:0]          out_first_r, out_first_nxt;
  logic [ROW_W-1:0]          out_final_r, out_final_nxt;
  logic [COLOR_W-1:0]        out_color_r, out_color_nxt;
  logic                      out_vis_r, out_vis_nxt;
  logic                      out_done_r, out_done_nxt;
  logic                      out_last_r, out_last_nxt;

  logic signed [MUL_W-1:0]   mul_a_s, mul_b_s;
  logic signed [DEC_W-1:0]   a2_d, b2_d, prod_d, term_d;
  logic signed [SLOPE_W-1:0] a2_x2, b2_x2;
  logic signed [TERM_W-1:0]  sx_t, sy_t, a2_t, b2_t;
  logic signed [COORD_W-1:0] tx_s, ty_s;
  logic                      slot_free;

  logic signed [SPAN_W-1:0]  sp_off, sp_col, sp_top, sp_bot, top_c, bot_c;
  logic                      sp_vis;

  // one multiplier shared by setup and region change, product always registered
  assign prod_nxt = mul_a_s * mul_b_s;

  assign a2_d   = DEC_W'(a2_r);
  assign b2_d   = DEC_W'(b2_r);
  assign prod_d = prod_r[DEC_W-1:0];
  assign term_d = DEC_W'(term_r);
  assign a2_x2  = SLOPE_W'({a2_r, 1'b0});
  assign b2_x2  = SLOPE_W'({b2_r, 1'b0});
  assign sx_t   = TERM_W'(sx_r);
  assign sy_t   = TERM_W'(sy_r);
  assign a2_t   = TERM_W'(a2_r);
  assign b2_t   = TERM_W'(b2_r);
  assign tx_s   = {step_x_r, 1'b1};
  assign ty_s   = COORD_W'(step_y_r) - COORD_W'(1);

  assign slot_free = !out_valid_r || out_tready;

  // span of the saved column offset, mirrored while in the second emit state
  always_comb begin
    sp_off = (state_r == ST_EMIT_NEG) ? -SPAN_W'(x0_r) : SPAN_W'(x0_r);
    sp_col = SPAN_W'(centre_col_r) + sp_off;
    sp_top = SPAN_W'(centre_row_r) - SPAN_W'(y0_r);
    sp_bot = SPAN_W'(centre_row_r) + SPAN_W'(y0_r);
    top_c  = (sp_top < 0) ? '0 : sp_top;
    bot_c  = (sp_bot > ROW_MAX) ? ROW_MAX : sp_bot;
    sp_vis = (sp_col >= 0) && (sp_col < COL_LIM) && (top_c <= bot_c);
  end

  always_comb begin
    state_nxt      = state_r;
    centre_col_nxt = centre_col_r;
    centre_row_nxt = centre_row_r;
    axis_a_nxt     = axis_a_r;
    axis_b_nxt     = axis_b_r;
    a2_nxt         = a2_r;
    b2_nxt         = b2_r;
    step_x_nxt     = step_x_r;
    step_y_nxt     = step_y_r;
    x0_nxt         = x0_r;
    y0_nxt         = y0_r;
    dec_nxt        = dec_r;
    acc_nxt        = acc_r;
    sx_nxt         = sx_r;
    sy_nxt         = sy_r;
    term_nxt       = term_r;
    ystep_nxt      = ystep_r;
    xstep_nxt      = xstep_r;
    tr_nxt         = tr_r;
    region2_nxt    = region2_r;
    finished_nxt   = finished_r;
    color_nxt      = color_r;
    mul_a_s        = '0;
    mul_b_s        = '0;
    cmd_pop        = 1'b0;

    out_valid_nxt  = out_valid_r && !out_tready;
    out_col_nxt    = out_col_r;
    out_first_nxt  = out_first_r;
    out_final_nxt  = out_final_r;
    out_color_nxt  = out_color_r;
    out_vis_nxt    = out_vis_r;
    out_done_nxt   = out_done_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.is_begin) begin
            // a begin drops whatever ellipse was in progress
            centre_col_nxt = cmd.centre_col;
            centre_row_nxt = cmd.centre_row;
            color_nxt      = cmd.color;
            axis_a_nxt     = cmd.axis_a;
            axis_b_nxt     = cmd.axis_b;
            region2_nxt    = 1'b0;
            step_x_nxt     = '0;
            step_y_nxt     = '0;
            dec_nxt        = '0;
            sx_nxt         = '0;
            sy_nxt         = '0;
            a2_nxt         = '0;
            b2_nxt         = '0;
            finished_nxt   = cmd.degenerate;
            state_nxt      = cmd.degenerate ? ST_IDLE : ST_MUL_AA;
          end else if (finished_r) begin
            state_nxt = ST_EMIT_DONE;
          end else begin
            x0_nxt    = step_x_r;
            y0_nxt    = step_y_r;
            state_nxt = region2_r ? ST_R2_STEP : ST_R1_STEP;
          end
        end
      end

      ST_MUL_AA: begin
        mul_a_s   = MUL_W'(axis_a_r);
        mul_b_s   = MUL_W'(axis_a_r);
        state_nxt = ST_MUL_BB;
      end

      ST_MUL_BB: begin
        a2_nxt    = prod_r[A2_W-1:0];
        mul_a_s   = MUL_W'(axis_b_r);
        mul_b_s   = MUL_W'(axis_b_r);
        state_nxt = ST_MUL_AB;
      end

      ST_MUL_AB: begin
        b2_nxt    = prod_r[A2_W-1:0];
        mul_a_s   = MUL_W'(a2_r);
        mul_b_s   = MUL_W'(axis_b_r);
        state_nxt = ST_SETUP;
      end

      ST_SETUP: begin
        // product holds a^2*b
        step_y_nxt   = STEP_W'(axis_b_r);
        sy_nxt       = {prod_r[SLOPE_W-2:0], 1'b0};
        dec_nxt      = (b2_d <<< 2) - (prod_d <<< 2) + a2_d;
        finished_nxt = 1'b0;
        state_nxt    = ST_IDLE;
      end

      ST_R1_STEP: begin
        step_x_nxt = step_x_r + STEP_W'(1);
        sx_nxt     = sx_r + b2_x2;
        ystep_nxt  = !dec_r[DEC_W-1];
        if (!dec_r[DEC_W-1]) begin
          step_y_nxt = step_y_r - STEP_W'(1);
          sy_nxt     = sy_r - a2_x2;
        end
        state_nxt = ST_R1_TERM;
      end

      ST_R1_TERM: begin
        term_nxt  = sx_t - (ystep_r ? sy_t : '0) + b2_t;
        tr_nxt    = (sx_r >= sy_r);
        state_nxt = ST_R1_ACC;
      end

      ST_R1_ACC: begin
        dec_nxt = dec_r + (term_d <<< 2);
        if (tr_r) begin
          state_nxt = ST_TR_TX;
        end else begin
          finished_nxt = step_y_r[STEP_W-1];
          state_nxt    = ST_EMIT_POS;
        end
      end

      // region change: decision restarts at (x+1/2, y-1), scaled by four
      ST_TR_TX: begin
        mul_a_s   = MUL_W'(tx_s);
        mul_b_s   = MUL_W'(tx_s);
        state_nxt = ST_TR_BTX;
      end

      ST_TR_BTX: begin
        mul_a_s   = MUL_W'(b2_r);
        mul_b_s   = prod_r[MUL_W-1:0];
        state_nxt = ST_TR_TY;
      end

      ST_TR_TY: begin
        acc_nxt   = prod_d;
        mul_a_s   = MUL_W'(ty_s);
        mul_b_s   = MUL_W'(ty_s);
        state_nxt = ST_TR_ATY;
      end

      ST_TR_ATY: begin
        mul_a_s   = MUL_W'(a2_r);
        mul_b_s   = prod_r[MUL_W-1:0];
        state_nxt = ST_TR_AB;
      end

      ST_TR_AB: begin
        acc_nxt   = acc_r + (prod_d <<< 2);
        mul_a_s   = MUL_W'(a2_r);
        mul_b_s   = MUL_W'(b2_r);
        state_nxt = ST_TR_FIN;
      end

      ST_TR_FIN: begin
        dec_nxt      = acc_r - (prod_d <<< 2);
        region2_nxt  = 1'b1;
        finished_nxt = step_y_r[STEP_W-1];
        state_nxt    = ST_EMIT_POS;
      end

      // region two: y steps repeat until x moves or y runs out
      ST_R2_STEP: begin
        step_y_nxt = step_y_r - STEP_W'(1);
        sy_nxt     = sy_r - a2_x2;
        xstep_nxt  = dec_r[DEC_W-1] || (dec_r == '0);
        if (dec_r[DEC_W-1] || (dec_r == '0)) begin
          step_x_nxt = step_x_r + STEP_W'(1);
          sx_nxt     = sx_r + b2_x2;
        end
        state_nxt = ST_R2_TERM;
      end

      ST_R2_TERM: begin
        term_nxt  = (xstep_r ? sx_t : '0) - sy_t + a2_t;
        state_nxt = ST_R2_ACC;
      end

      ST_R2_ACC: begin
        dec_nxt = dec_r + (term_d <<< 2);
        if (step_y_r[STEP_W-1]) begin
          finished_nxt = 1'b1;
          state_nxt    = ST_EMIT_POS;
        end else if (xstep_r) begin
          state_nxt = ST_EMIT_POS;
        end else begin
          state_nxt = ST_R2_STEP;
        end
      end

      ST_EMIT_POS, ST_EMIT_NEG: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_col_nxt   = sp_col[COL_W-1:0];
          out_first_nxt = sp_vis ? top_c[ROW_W-1:0] : '0;
          out_final_nxt = sp_vis ? bot_c[ROW_W-1:0] : '0;
          out_color_nxt = color_r;
          out_vis_nxt   = sp_vis;
          out_done_nxt  = finished_r;
          if ((state_r == ST_EMIT_POS) && (x0_r > 0)) begin
            out_last_nxt = 1'b0;
            state_nxt    = ST_EMIT_NEG;
          end else begin
            out_last_nxt = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end
      end

      ST_EMIT_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_col_nxt   = '0;
          out_first_nxt = '0;
          out_final_nxt = '0;
          out_color_nxt = color_r;
          out_vis_nxt   = 1'b0;
          out_done_nxt  = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      finished_r  <= 1'b1;
      region2_r   <= 1'b0;
      color_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      finished_r  <= finished_nxt;
      region2_r   <= region2_nxt;
      color_r     <= color_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    centre_col_r <= centre_col_nxt;
    centre_row_r <= centre_row_nxt;
    axis_a_r     <= axis_a_nxt;
    axis_b_r     <= axis_b_nxt;
    a2_r         <= a2_nxt;
    b2_r         <= b2_nxt;
    step_x_r     <= step_x_nxt;
    step_y_r     <= step_y_nxt;
    x0_r         <= x0_nxt;
    y0_r         <= y0_nxt;
    dec_r        <= dec_nxt;
    acc_r        <= acc_nxt;
    sx_r         <= sx_nxt;
    sy_r         <= sy_nxt;
    term_r       <= term_nxt;
    prod_r       <= prod_nxt;
    ystep_r      <= ystep_nxt;
    xstep_r      <= xstep_nxt;
    tr_r         <= tr_nxt;
    out_col_r    <= out_col_nxt;
    out_first_r  <= out_first_nxt;
    out_final_r  <= out_final_nxt;
    out_color_r  <= out_color_nxt;
    out_vis_r    <= out_vis_nxt;
    out_done_r   <= out_done_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_color_r, out_final_r, out_first_r, out_col_r};
  assign out_tlast  = out_last_r;
  always_comb begin
    out_tuser               = '0;
    out_tuser[USER_VISIBLE] = out_vis_r;
    out_tuser[USER_DONE]    = out_done_r;
  end

  a_walk_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_R1_STEP || state_r == ST_R1_TERM || state_r == ST_R1_ACC ||
     state_r == ST_R2_STEP || state_r == ST_R2_TERM || state_r == ST_R2_ACC ||
     state_r == ST_TR_TX) |-> !finished_r)
    else $error("ellipse walk running on a finished ellipse");

  a_vis_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_vis_r) |-> (out_first_r <= out_final_r))
    else $error("visible span with first row below final row");

  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_vis_r) |-> (out_first_r == '0 && out_final_r == '0))
    else $error("hidden span carries nonzero rows");

  a_mirror_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_NEG) |-> (x0_r > 0))
    else $error("mirrored span for a zero column offset");

endmodule

@@ src/ellipse_span_rasterizer.sv @@
// top level of the filled-ellipse vertical span rasterizer
// a next beat runs the step, term and accumulate states before its first span in region one,
//   adds the region-change multiplies on the column where region two starts, and in region two
//   repeats the step, term and accumulate states once per y step in that column
// a begin beat runs the a^2, b^2 and a^2*b multiplies and setup on the shared multiplier
// a mirrored second span adds the second emit state; a new beat is taken only from idle
// reset: synchronous active low; queue and result register empty, ellipse finished, colour zero
module ellipse_span_rasterizer import esr_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input beats
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // box_left, box_top, box_width, box_height, fill_color
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // req_type
  input  logic [IN_USER_W-1:0]  in_tuser,
  // result beats
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // column, row_first, row_final, span_color, zero padding
  output logic [OUT_DATA_W-1:0] out_tdata,
  // visible, ellipse_done
  output logic [OUT_USER_W-1:0] out_tuser,
  // last_of_run
  output logic                  out_tlast
);

  // decoded command from the front end into the queue
  cmd_t push_cmd;
  logic push;
  logic q_full;

  // command at the head of the queue for the span engine
  cmd_t head_cmd;
  logic head_valid;
  logic head_pop;

  // front end: box halving, centre and degenerate check per beat
  esr_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (push),
    .q_cmd     (push_cmd)
  );

  // queue lets input beats land while the engine walks or the output stalls
  esr_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (head_pop),
    .pop_cmd  (head_cmd),
    .valid    (head_valid)
  );

  // engine: setup multiplies, two-region walk, clipping and result register
  esr_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (head_valid),
    .cmd        (head_cmd),
    .cmd_pop    (head_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
